>>> hdl/tkv_pkg.sv
// ----------------------------------------------------------------------------
// tkv_pkg
// Shared types and constants of the key-value record store unit.
// ----------------------------------------------------------------------------
package tkv_pkg;

  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_FIND  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_SIZE  = 3'd4;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam logic [8:0] USED_MAX = 9'd511;

  typedef struct packed {
    logic [7:0] addend;
    logic [1:0] inc;
  } alu_op_t;

  typedef struct packed {
    logic ge_end;
    logic gt_end;
  } alu_flags_t;

endpackage

>>> hdl/tlv_key_value_store_unit.sv
// ----------------------------------------------------------------------------
// tlv_key_value_store_unit
// Byte store of key-length-value records with load, read, find, write and
// size requests, walked record by record under a small sequencer.
// ----------------------------------------------------------------------------
//   Channel  Direction  Beat content
//   s_axis   in         one request
//   m_axis   out        one result per request
//
// After reset every byte of the store is cleared and s_axis_tready stays
// low meanwhile. A load or an unknown request goes straight to the result
// state; a read first reads its byte, unless its address lies outside the
// store. A find, write or size request walks the records, reading each key
// and length byte, and ends on the terminator, on a match (where a write may
// store its byte), or when it runs past the store end at a key, length or value byte.
// A result waits in the output register, and a new request is taken
// meanwhile; the sequencer holds only if its own result finds it still full.
module tlv_key_value_store_unit #(
  parameter int STORE_BYTES = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // req_type[2:0], address[10:3], key[18:11], data[26:19],
  // write_len[34:27], byte_offset[42:35], zero fill[47:43]
  input  logic [tkv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // found[0], value_address[8:1], value_length[16:9], read_data[24:17],
  // used_size[33:25], overrun[34], zero fill[39:35]
  output logic [tkv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PW = ((AW > 8) ? AW : 8) + 2;
  localparam logic [PW-1:0] StoreEnd = PW'(STORE_BYTES);
  localparam logic [AW-1:0] LastAddr = AW'(STORE_BYTES - 1);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_KEY  = 4'd3;
  localparam logic [3:0] ST_KEYW = 4'd4;
  localparam logic [3:0] ST_LENW = 4'd5;
  localparam logic [3:0] ST_CHK  = 4'd6;
  localparam logic [3:0] ST_WR   = 4'd7;
  localparam logic [3:0] ST_RES  = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [2:0]    req_q;
  logic [7:0]    key_q, data_q, wlen_q, off_q;
  logic [PW-1:0] p_q, end_q;
  logic          over_q, kmatch_q;
  logic [7:0]    len_q;

  logic          res_found_q, res_over_q;
  logic [7:0]    res_vaddr_q, res_vlen_q, res_rdata_q;
  logic [8:0]    res_used_q;

  logic                            out_valid_q;
  logic [tkv_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic [2:0]    in_req;
  logic [7:0]    in_addr, in_key, in_data, in_wlen, in_off;
  logic [PW-1:0] in_addr_ext;
  logic          in_addr_ok, accept, out_free;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  tkv_pkg::alu_op_t    alu_op;
  tkv_pkg::alu_flags_t alu_flags;
  logic [PW-1:0]       alu_sum;

  assign in_req      = s_axis_tdata[2:0];
  assign in_addr     = s_axis_tdata[10:3];
  assign in_key      = s_axis_tdata[18:11];
  assign in_data     = s_axis_tdata[26:19];
  assign in_wlen     = s_axis_tdata[34:27];
  assign in_off      = s_axis_tdata[42:35];
  assign in_addr_ext = PW'(in_addr);
  assign in_addr_ok  = (in_addr_ext < StoreEnd);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  tkv_alu #(
    .STORE_BYTES(STORE_BYTES),
    .PW         (PW)
  ) u_alu (
    .ptr_i  (p_q),
    .op_i   (alu_op),
    .sum_o  (alu_sum),
    .flags_o(alu_flags)
  );

  tkv_mem #(
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    alu_op.addend = 8'd0;
    alu_op.inc    = 2'd0;
    mem_we        = 1'b0;
    mem_waddr     = clr_q;
    mem_wdata     = 8'd0;
    mem_raddr     = p_q[AW-1:0];
    state_d       = state_q;
    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = in_addr_ext[AW-1:0];
        if (accept) begin
          case (in_req)
            tkv_pkg::REQ_LOAD: begin
              mem_we    = in_addr_ok;
              mem_waddr = in_addr_ext[AW-1:0];
              mem_wdata = in_data;
              state_d   = ST_RES;
            end
            tkv_pkg::REQ_READ: begin
              state_d = in_addr_ok ? ST_RD : ST_RES;
            end
            tkv_pkg::REQ_FIND, tkv_pkg::REQ_WRITE, tkv_pkg::REQ_SIZE: begin
              state_d = ST_KEY;
            end
            default: begin
              state_d = ST_RES;
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_RES;
      end
      ST_KEY: begin
        state_d = alu_flags.ge_end ? ST_RES : ST_KEYW;
      end
      ST_KEYW: begin
        alu_op.inc = 2'd1;
        mem_raddr  = alu_sum[AW-1:0];
        if (mem_rdata == 8'd0 || alu_flags.ge_end) begin
          state_d = ST_RES;
        end else begin
          state_d = ST_LENW;
        end
      end
      ST_LENW: begin
        alu_op.addend = mem_rdata;
        alu_op.inc    = 2'd2;
        state_d       = ST_CHK;
      end
      ST_CHK: begin
        alu_op.inc = 2'd2;
        if (over_q) begin
          state_d = ST_RES;
        end else if (req_q != tkv_pkg::REQ_SIZE && kmatch_q &&
                     (req_q != tkv_pkg::REQ_WRITE || len_q >= wlen_q)) begin
          if (req_q == tkv_pkg::REQ_WRITE && off_q < wlen_q) begin
            state_d = ST_WR;
          end else begin
            state_d = ST_RES;
          end
        end else begin
          state_d = ST_KEY;
        end
      end
      ST_WR: begin
        alu_op.addend = off_q;
        alu_op.inc    = 2'd2;
        mem_we        = 1'b1;
        mem_waddr     = alu_sum[AW-1:0];
        mem_wdata     = data_q;
        state_d       = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ST_RES && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_q       <= in_req;
          key_q       <= in_key;
          data_q      <= in_data;
          wlen_q      <= in_wlen;
          off_q       <= in_off;
          p_q         <= '0;
          res_found_q <= 1'b0;
          res_over_q  <= 1'b0;
          res_vaddr_q <= 8'd0;
          res_vlen_q  <= 8'd0;
          res_rdata_q <= 8'd0;
          res_used_q  <= 9'd0;
        end
      end
      ST_RD: begin
        res_rdata_q <= mem_rdata;
      end
      ST_KEY: begin
        if (alu_flags.ge_end) begin
          res_over_q <= 1'b1;
        end
      end
      ST_KEYW: begin
        kmatch_q <= (mem_rdata == key_q);
        if (mem_rdata == 8'd0) begin
          if (req_q == tkv_pkg::REQ_SIZE) begin
            res_used_q <= (alu_sum > PW'(tkv_pkg::USED_MAX)) ?
                          tkv_pkg::USED_MAX : alu_sum[8:0];
          end
        end else if (alu_flags.ge_end) begin
          res_over_q <= 1'b1;
        end
      end
      ST_LENW: begin
        len_q  <= mem_rdata;
        end_q  <= alu_sum;
        over_q <= alu_flags.gt_end;
      end
      ST_CHK: begin
        if (over_q) begin
          res_over_q <= 1'b1;
        end else if (req_q != tkv_pkg::REQ_SIZE && kmatch_q &&
                     (req_q != tkv_pkg::REQ_WRITE || len_q >= wlen_q)) begin
          res_found_q <= 1'b1;
          res_vaddr_q <= alu_sum[7:0];
          res_vlen_q  <= len_q;
        end else begin
          p_q <= end_q;
        end
      end
      ST_RES: begin
        if (out_free) begin
          out_data_q <= {5'd0, res_over_q, res_used_q, res_rdata_q,
                         res_vlen_q, res_vaddr_q, res_found_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/tkv_mem.sv
// ----------------------------------------------------------------------------
// tkv_mem
// Record store memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tkv_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tkv_alu.sv
// ----------------------------------------------------------------------------
// tkv_alu
// Shared pointer adder with compares against the end of the store.
// ----------------------------------------------------------------------------
module tkv_alu #(
  parameter int STORE_BYTES = 256,
  parameter int PW          = 10
) (
  input  logic [PW-1:0]        ptr_i,
  input  tkv_pkg::alu_op_t     op_i,
  output logic [PW-1:0]        sum_o,
  output tkv_pkg::alu_flags_t  flags_o
);

  localparam logic [PW-1:0] StoreEnd = PW'(STORE_BYTES);

  always_comb begin
    sum_o = ptr_i + PW'(op_i.addend) + PW'(op_i.inc);
    flags_o.ge_end = (sum_o >= StoreEnd);
    flags_o.gt_end = (sum_o > StoreEnd);
  end

endmodule

>>> hdl/tkv_checker.sv
// ----------------------------------------------------------------------------
// tkv_checker
// Port-level checks of the key-value record store unit.
// ----------------------------------------------------------------------------
module tkv_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [tkv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tkv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // A held result beat must not disappear before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // Every taken request makes the unit busy and drops s_axis_tready.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken on two consecutive cycles");

  a_found_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[34]))
    else $error("found and overrun set together");

  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[33:17] == 17'd0)
    else $error("found result carries read data or size");

endmodule

bind tlv_key_value_store_unit tkv_checker u_tkv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
